FILE: src/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_READ_BYTE = 2'd2;
    localparam logic [1:0] CMD_READ_WORD = 2'd3;

    // kinds of sequence step
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_SEND  = 3'd2;
    localparam logic [2:0] KIND_ACK   = 3'd3;
    localparam logic [2:0] KIND_RECV  = 3'd4;
    localparam logic [2:0] KIND_NACK  = 3'd5;
    localparam logic [2:0] KIND_STOP  = 3'd6;

    // source of the byte shifted out by a send step
    localparam logic [2:0] SRC_NONE = 3'd0;
    localparam logic [2:0] SRC_AW   = 3'd1;
    localparam logic [2:0] SRC_AR   = 3'd2;
    localparam logic [2:0] SRC_REG  = 3'd3;
    localparam logic [2:0] SRC_REG1 = 3'd4;
    localparam logic [2:0] SRC_DATA = 3'd5;

    localparam int PHASE_W = 5;

    // landmark steps of the sequence
    localparam logic [PHASE_W-1:0] STEP_IDLE       = 5'd0;
    localparam logic [PHASE_W-1:0] STEP_WR_START   = 5'd1;
    localparam logic [PHASE_W-1:0] STEP_WR_STOP    = 5'd8;
    localparam logic [PHASE_W-1:0] STEP_RD_START   = 5'd9;
    localparam logic [PHASE_W-1:0] STEP_RD_STOP    = 5'd19;
    localparam logic [PHASE_W-1:0] STEP_RD2_START  = 5'd20;
    localparam logic [PHASE_W-1:0] STEP_LAST       = 5'd30;

    // register indexes on the config port
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_HALF_PERIOD    = 1'b1;

    // reset values; the address byte for a write is 8'hD0
    localparam logic [6:0] DEV_ADDR_RESET    = 7'd104;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] half_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        nack_seen;
    } res_t;

    function automatic logic [2:0] step_kind(input logic [PHASE_W-1:0] p);
        logic [2:0] k;
        case (p)
            5'd1, 5'd9, 5'd14, 5'd20, 5'd25:              k = KIND_START;
            5'd2, 5'd4, 5'd6, 5'd10, 5'd12, 5'd15,
            5'd21, 5'd23, 5'd26:                          k = KIND_SEND;
            5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd16,
            5'd22, 5'd24, 5'd27:                          k = KIND_ACK;
            5'd17, 5'd28:                                 k = KIND_RECV;
            5'd18, 5'd29:                                 k = KIND_NACK;
            5'd8, 5'd19, 5'd30:                           k = KIND_STOP;
            default:                                      k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] step_src(input logic [PHASE_W-1:0] p);
        logic [2:0] s;
        case (p)
            5'd2, 5'd10, 5'd21: s = SRC_AW;
            5'd15, 5'd26:       s = SRC_AR;
            5'd4, 5'd12:        s = SRC_REG;
            5'd23:              s = SRC_REG1;
            5'd6:               s = SRC_DATA;
            default:            s = SRC_NONE;
        endcase
        return s;
    endfunction

    // number of pin phases in a step
    function automatic logic [4:0] kind_len(input logic [2:0] k);
        logic [4:0] n;
        case (k)
            KIND_START: n = 5'd4;
            KIND_SEND:  n = 5'd16;
            KIND_ACK:   n = 5'd2;
            KIND_RECV:  n = 5'd16;
            KIND_NACK:  n = 5'd2;
            KIND_STOP:  n = 5'd3;
            default:    n = 5'd1;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: src/i2c_master_register_access_core.sv
// bit-level i2c master for single-register write, byte read and word read
//
// input stream: every accepted transaction is one tick of the bus sequencer.
//   tuser carries the command (tick, write, read byte, read word); a command
//   is taken only while idle and ignored while busy. sda_in is the sampled
//   bus level for that tick.
// output stream: exactly one result transaction per input transaction, in
//   order, carrying the scl/sda levels to drive, busy, the last read value and
//   the nack flag. tlast is high on the tick that ends a bus transaction.
// config: apb, reg 0 at 0x0 device address, reg 1 at 0x4 half period ticks;
//   write only while idle. pready is tied high.
// path: a tick passes through the input register and then the result
//   register. throughput: one tick per clock while results are taken; the
//   sequencer state updates in a single pass from the input register to the
//   result register. stall: when the result is not taken the result register
//   holds, the input register takes one more tick only if empty, then tready drops.
// reset: sequencer idle, read value and flags zero, device address 0x68,
//   half period one tick.
`default_nettype none
module i2c_master_register_access_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // reg_addr[7:0], wr_data[15:8], sda_in[16]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // scl[0], sda[1], busy[2], read_data[18:3], nack[19]
    output logic             m_axis_tlast,   // done_res
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    i2cm_pkg::cfg_t  cfg;
    i2cm_pkg::item_t item_reg;
    i2cm_pkg::res_t  res;
    i2cm_pkg::res_t  out_reg;
    logic            in_vld_reg;
    logic            out_vld_reg;
    logic            advance;
    logic            in_take;

    assign pready = 1'b1;

    i2cm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // the held tick moves on when the result slot is free or being emptied
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_axis_tready)
            in_vld_reg <= s_axis_tvalid;
    end

    // input payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd      <= s_axis_tuser;
            item_reg.reg_addr <= s_axis_tdata[7:0];
            item_reg.wr_data  <= s_axis_tdata[15:8];
            item_reg.sda_in   <= s_axis_tdata[16];
        end
    end

    i2cm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, out_reg.nack_seen, out_reg.read_data,
                            out_reg.busy_res, out_reg.sda_level, out_reg.scl_level};
    assign m_axis_tlast  = out_reg.done_res;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_axis_tready)
        else $error("input refused with empty input register");

    a_tick_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("processed tick gave no result");

endmodule
`default_nettype wire

FILE: src/i2cm_regs.sv
`default_nettype none
module i2cm_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output i2cm_pkg::cfg_t     cfg
);

    logic [6:0] dev_reg;
    logic [7:0] half_reg;
    logic       wr_en;

    // byte offset bits are ignored, register select is the word bit
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg  <= i2cm_pkg::DEV_ADDR_RESET;
            half_reg <= i2cm_pkg::HALF_PERIOD_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == i2cm_pkg::REG_DEVICE_ADDRESS)
                dev_reg <= pwdata[6:0];
            else
                half_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == i2cm_pkg::REG_DEVICE_ADDRESS)
            prdata = {25'd0, dev_reg};
        else
            prdata = {24'd0, half_reg};
    end

    assign cfg.device_address    = dev_reg;
    assign cfg.half_period_ticks = half_reg;

endmodule
`default_nettype wire

FILE: src/i2cm_seq.sv
`default_nettype none
module i2cm_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire i2cm_pkg::item_t item,
    input  wire i2cm_pkg::cfg_t  cfg,
    output i2cm_pkg::res_t       res
);

    localparam int PW = i2cm_pkg::PHASE_W;

    logic [PW-1:0] phase_reg, phase_next, cur_phase, np;
    logic [3:0]    bit_reg, bit_next, cur_bit;
    logic [7:0]    timer_reg, timer_next, cur_timer;
    logic [7:0]    shift_reg, shift_next;
    logic [7:0]    word_hi_reg, word_hi_next;
    logic [1:0]    op_reg, op_next;
    logic [7:0]    hreg_reg, hreg_next;
    logic [7:0]    hdata_reg, hdata_next;
    logic          ack_reg, ack_next;
    logic [15:0]   last_reg, last_next;
    logic [2:0]    kind;
    logic [7:0]    half;
    logic [8:0]    tick_sum;
    logic [4:0]    sub_inc;
    logic [2:0]    s_stop;
    logic          scl_o, sda_o, done_o;

    always_comb
    begin
        op_next      = op_reg;
        hreg_next    = hreg_reg;
        hdata_next   = hdata_reg;
        ack_next     = ack_reg;
        word_hi_next = word_hi_reg;
        shift_next   = shift_reg;
        last_next    = last_reg;
        cur_phase    = phase_reg;
        cur_bit      = bit_reg;
        cur_timer    = timer_reg;
        scl_o        = 1'b1;
        sda_o        = 1'b1;
        done_o       = 1'b0;
        np           = phase_reg + 5'd1;
        s_stop       = 3'd0;
        tick_sum     = 9'd0;
        sub_inc      = 5'd0;

        // new command while idle; its first tick is the first start phase
        if (phase_reg == i2cm_pkg::STEP_IDLE && item.cmd != i2cm_pkg::CMD_TICK)
        begin
            op_next      = item.cmd;
            hreg_next    = item.reg_addr;
            hdata_next   = item.wr_data;
            ack_next     = 1'b0;
            word_hi_next = 8'd0;
            cur_phase    = (item.cmd == i2cm_pkg::CMD_WRITE) ? i2cm_pkg::STEP_WR_START
                                                             : i2cm_pkg::STEP_RD_START;
            cur_bit      = 4'd0;
            cur_timer    = 8'd0;
        end

        kind       = i2cm_pkg::step_kind(cur_phase);
        half       = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
        phase_next = cur_phase;
        bit_next   = cur_bit;
        timer_next = cur_timer;

        if (cur_phase != i2cm_pkg::STEP_IDLE)
        begin
            case (kind)
                i2cm_pkg::KIND_START:
                begin
                    scl_o = cur_bit[0] ^ cur_bit[1];
                    sda_o = !cur_bit[1];
                end
                i2cm_pkg::KIND_STOP:
                begin
                    s_stop = (cur_bit < 4'd3) ? cur_bit[2:0] : 3'd2;
                    scl_o  = (s_stop != 3'd0);
                    sda_o  = (s_stop == 3'd2);
                end
                i2cm_pkg::KIND_SEND:
                begin
                    scl_o = cur_bit[0];
                    sda_o = shift_reg[~cur_bit[3:1]];
                end
                default:
                begin
                    scl_o = cur_bit[0];
                    sda_o = 1'b1;
                end
            endcase

            tick_sum = {1'b0, cur_timer} + 9'd1;
            if (tick_sum >= {1'b0, half})
            begin
                timer_next = 8'd0;
                // sample at the end of the scl high phase
                if (cur_bit[0])
                begin
                    if (kind == i2cm_pkg::KIND_ACK)
                        ack_next = ack_next | item.sda_in;
                    else if (kind == i2cm_pkg::KIND_RECV)
                        shift_next = {shift_reg[6:0], item.sda_in};
                end
                sub_inc  = {1'b0, cur_bit} + 5'd1;
                bit_next = sub_inc[3:0];
                if (sub_inc >= i2cm_pkg::kind_len(kind))
                begin
                    np = cur_phase + 5'd1;
                    if (cur_phase == i2cm_pkg::STEP_WR_STOP)
                    begin
                        phase_next = i2cm_pkg::STEP_IDLE;
                        done_o     = 1'b1;
                    end
                    else if (cur_phase == i2cm_pkg::STEP_RD_STOP &&
                             op_next == i2cm_pkg::CMD_READ_WORD)
                    begin
                        // high byte done, second byte read at reg+1
                        word_hi_next = shift_next;
                        phase_next   = i2cm_pkg::STEP_RD2_START;
                        bit_next     = 4'd0;
                    end
                    else if (cur_phase == i2cm_pkg::STEP_RD_STOP)
                    begin
                        last_next  = {8'd0, shift_next};
                        phase_next = i2cm_pkg::STEP_IDLE;
                        done_o     = 1'b1;
                    end
                    else if (cur_phase == i2cm_pkg::STEP_LAST)
                    begin
                        last_next  = {word_hi_next, shift_next};
                        phase_next = i2cm_pkg::STEP_IDLE;
                        done_o     = 1'b1;
                    end
                    else
                    begin
                        phase_next = np;
                        bit_next   = 4'd0;
                        if (i2cm_pkg::step_kind(np) == i2cm_pkg::KIND_SEND)
                        begin
                            case (i2cm_pkg::step_src(np))
                                i2cm_pkg::SRC_AW:   shift_next = {cfg.device_address, 1'b0};
                                i2cm_pkg::SRC_AR:   shift_next = {cfg.device_address, 1'b1};
                                i2cm_pkg::SRC_REG:  shift_next = hreg_next;
                                i2cm_pkg::SRC_REG1: shift_next = hreg_next + 8'd1;
                                default:            shift_next = hdata_next;
                            endcase
                        end
                    end
                end
            end
            else
            begin
                timer_next = tick_sum[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cm_pkg::STEP_IDLE;
            bit_reg     <= 4'd0;
            timer_reg   <= 8'd0;
            shift_reg   <= 8'd0;
            word_hi_reg <= 8'd0;
            op_reg      <= 2'd0;
            hreg_reg    <= 8'd0;
            hdata_reg   <= 8'd0;
            ack_reg     <= 1'b0;
            last_reg    <= 16'd0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            timer_reg   <= timer_next;
            shift_reg   <= shift_next;
            word_hi_reg <= word_hi_next;
            op_reg      <= op_next;
            hreg_reg    <= hreg_next;
            hdata_reg   <= hdata_next;
            ack_reg     <= ack_next;
            last_reg    <= last_next;
        end
    end

    assign res.scl_level = scl_o;
    assign res.sda_level = sda_o;
    assign res.busy_res  = (phase_next != i2cm_pkg::STEP_IDLE);
    assign res.done_res  = done_o;
    assign res.read_data = last_next;
    assign res.nack_seen = ack_next;

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && done_o) |=> (phase_reg == i2cm_pkg::STEP_IDLE))
        else $error("transaction end did not return to idle");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= i2cm_pkg::STEP_LAST)
        else $error("sequence step out of range");

    a_bit_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != i2cm_pkg::STEP_IDLE) |->
        ({1'b0, bit_reg} < i2cm_pkg::kind_len(i2cm_pkg::step_kind(phase_reg))))
        else $error("bit index beyond step length");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> ($stable(phase_reg) && $stable(timer_reg) && $stable(bit_reg)))
        else $error("sequencer moved without a tick");

endmodule
`default_nettype wire
